[rtl/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, command codes and control/status types of the first-fit
// block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int ARENA_BYTES  = 65536;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_BYTES  = 8;
    localparam int MIN_PAYLOAD  = 8;

    localparam int OFF_W   = 16;
    localparam int GRAN_W  = $clog2(ALIGN_BYTES);
    localparam int IDX_W   = OFF_W - GRAN_W;
    localparam int DEPTH   = ARENA_BYTES / ALIGN_BYTES;
    localparam int TAG_W   = OFF_W + 1;
    localparam int LINK_W  = IDX_W + 1;
    localparam int NEED_W  = OFF_W + 1;

    localparam logic [OFF_W-1:0] HDR_OFF   = OFF_W'(HEADER_BYTES);
    localparam logic [OFF_W-1:0] INIT_SIZE = OFF_W'(ARENA_BYTES - 2 * HEADER_BYTES);
    localparam logic [IDX_W-1:0] SENT_IDX  = IDX_W'((ARENA_BYTES - HEADER_BYTES) / ALIGN_BYTES);

    typedef logic [4:0] t_cmd;

    localparam t_cmd CMD_NOP     = 5'd0;
    localparam t_cmd CMD_INIT0   = 5'd1;
    localparam t_cmd CMD_INIT1   = 5'd2;
    localparam t_cmd CMD_LOAD    = 5'd3;
    localparam t_cmd CMD_A_SETUP = 5'd4;
    localparam t_cmd CMD_A_FIRST = 5'd5;
    localparam t_cmd CMD_A_STEP  = 5'd6;
    localparam t_cmd CMD_UNLINK  = 5'd7;
    localparam t_cmd CMD_A_SPL1  = 5'd8;
    localparam t_cmd CMD_A_SPL2  = 5'd9;
    localparam t_cmd CMD_A_NOSP  = 5'd10;
    localparam t_cmd CMD_PUSH1   = 5'd11;
    localparam t_cmd CMD_PUSH2   = 5'd12;
    localparam t_cmd CMD_F_SETUP = 5'd13;
    localparam t_cmd CMD_F_STEP  = 5'd14;
    localparam t_cmd CMD_F_RDUP  = 5'd15;
    localparam t_cmd CMD_F_UPCAP = 5'd16;
    localparam t_cmd CMD_F_RDLO  = 5'd17;
    localparam t_cmd CMD_CAPLNK  = 5'd18;
    localparam t_cmd CMD_F_RDUP2 = 5'd19;
    localparam t_cmd CMD_F_MERGE = 5'd20;
    localparam t_cmd CMD_F_WR    = 5'd21;
    localparam t_cmd CMD_FIN_OK  = 5'd22;
    localparam t_cmd CMD_FIN_BAD = 5'd23;

    typedef struct packed {
        logic is_free;
        logic need_zero;
        logic head_valid;
        logic fit;
        logic next_ok;
        logic split_ok;
        logic size_zero;
        logic at_h;
        logic q_free;
        logic pay_small;
        logic low_free;
        logic up_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/first_fit_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator over a 64 KiB arena with boundary tags and a doubly
// linked free list; allocate splits, free merges with both neighbors.
//
//   Channel  | Handshake             | Payload
//   ---------+-----------------------+-------------------------------------
//   request  | start, busy           | i_func, i_req_size, i_payload_addr
//   result   | o_done (1-cycle)      | o_result_addr, o_ok
//
// Allocate visits free-list nodes in turn from the head, then splits a large
// enough block and pushes the remainder. Free walks the blocks in turn from
// offset 0 up to the freed header, then merges and pushes. The walks are
// bound by one tag/link memory read per cycle.
// After reset an init pass writes the first block and the sentinel;
// busy is high meanwhile. Results cannot be stalled; busy is low while the
// result strobe is shown, so a new request may be taken in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_top
    import ffba_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_func,
    input  wire logic [OFF_W-1:0]  i_req_size,
    input  wire logic [OFF_W-1:0]  i_payload_addr,
    output logic                   o_done,
    output logic      [OFF_W-1:0]  o_result_addr,
    output logic                   o_ok
);

    t_cmd cmd;
    t_sts sts;

    ffba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    ffba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_req_size     (i_req_size),
        .i_payload_addr (i_payload_addr),
        .o_sts          (sts),
        .o_done         (o_done),
        .o_result_addr  (o_result_addr),
        .o_ok           (o_ok)
    );

endmodule

`default_nettype wire

[rtl/ffba_ram.sv]
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/ffba_ctrl.sv]
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: issues one datapath command per cycle for init, allocate and free.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_sts i_sts,
    output logic      busy,
    output t_cmd      o_cmd
);

    localparam logic [4:0] S_INIT0   = 5'd0;
    localparam logic [4:0] S_INIT1   = 5'd1;
    localparam logic [4:0] S_IDLE    = 5'd2;
    localparam logic [4:0] S_DISP    = 5'd3;
    localparam logic [4:0] S_A_SETUP = 5'd4;
    localparam logic [4:0] S_A_FIRST = 5'd5;
    localparam logic [4:0] S_A_STEP  = 5'd6;
    localparam logic [4:0] S_A_UNL   = 5'd7;
    localparam logic [4:0] S_A_SPL1  = 5'd8;
    localparam logic [4:0] S_A_SPL2  = 5'd9;
    localparam logic [4:0] S_A_NOSP  = 5'd10;
    localparam logic [4:0] S_PUSH1   = 5'd11;
    localparam logic [4:0] S_PUSH2   = 5'd12;
    localparam logic [4:0] S_F_SETUP = 5'd13;
    localparam logic [4:0] S_F_STEP  = 5'd14;
    localparam logic [4:0] S_F_RDUP  = 5'd15;
    localparam logic [4:0] S_F_UPCAP = 5'd16;
    localparam logic [4:0] S_F_RDLO  = 5'd17;
    localparam logic [4:0] S_F_LOCAP = 5'd18;
    localparam logic [4:0] S_F_LOUNL = 5'd19;
    localparam logic [4:0] S_F_RDUP2 = 5'd20;
    localparam logic [4:0] S_F_UPLCP = 5'd21;
    localparam logic [4:0] S_F_UPUNL = 5'd22;
    localparam logic [4:0] S_F_MERGE = 5'd23;
    localparam logic [4:0] S_F_WR    = 5'd24;
    localparam logic [4:0] S_FIN_OK  = 5'd25;
    localparam logic [4:0] S_FIN_BAD = 5'd26;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        unique case (r_state)
            S_INIT0: begin
                o_cmd   = CMD_INIT0;
                n_state = S_INIT1;
            end
            S_INIT1: begin
                o_cmd   = CMD_INIT1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = i_sts.is_free ? S_F_SETUP : S_A_SETUP;
            end
            S_A_SETUP: begin
                o_cmd = CMD_A_SETUP;
                if (i_sts.need_zero || !i_sts.head_valid) begin
                    n_state = S_FIN_BAD;
                end else begin
                    n_state = S_A_FIRST;
                end
            end
            S_A_FIRST: begin
                o_cmd   = CMD_A_FIRST;
                n_state = S_A_STEP;
            end
            S_A_STEP: begin
                o_cmd = CMD_A_STEP;
                if (i_sts.fit) begin
                    n_state = S_A_UNL;
                end else if (!i_sts.next_ok) begin
                    n_state = S_FIN_BAD;
                end
            end
            S_A_UNL: begin
                o_cmd   = CMD_UNLINK;
                n_state = i_sts.split_ok ? S_A_SPL1 : S_A_NOSP;
            end
            S_A_SPL1: begin
                o_cmd   = CMD_A_SPL1;
                n_state = S_A_SPL2;
            end
            S_A_SPL2: begin
                o_cmd   = CMD_A_SPL2;
                n_state = S_PUSH1;
            end
            S_A_NOSP: begin
                o_cmd   = CMD_A_NOSP;
                n_state = S_FIN_OK;
            end
            S_PUSH1: begin
                o_cmd   = CMD_PUSH1;
                n_state = S_PUSH2;
            end
            S_PUSH2: begin
                o_cmd   = CMD_PUSH2;
                n_state = S_FIN_OK;
            end
            S_F_SETUP: begin
                o_cmd   = CMD_F_SETUP;
                n_state = i_sts.pay_small ? S_FIN_BAD : S_F_STEP;
            end
            S_F_STEP: begin
                o_cmd = CMD_F_STEP;
                if (i_sts.size_zero) begin
                    n_state = S_FIN_BAD;
                end else if (i_sts.at_h) begin
                    n_state = i_sts.q_free ? S_FIN_BAD : S_F_RDUP;
                end
            end
            S_F_RDUP: begin
                o_cmd   = CMD_F_RDUP;
                n_state = S_F_UPCAP;
            end
            S_F_UPCAP: begin
                o_cmd = CMD_F_UPCAP;
                if (i_sts.low_free) begin
                    n_state = S_F_RDLO;
                end else if (i_sts.q_free) begin
                    n_state = S_F_RDUP2;
                end else begin
                    n_state = S_F_WR;
                end
            end
            S_F_RDLO: begin
                o_cmd   = CMD_F_RDLO;
                n_state = S_F_LOCAP;
            end
            S_F_LOCAP: begin
                o_cmd   = CMD_CAPLNK;
                n_state = S_F_LOUNL;
            end
            S_F_LOUNL: begin
                o_cmd   = CMD_UNLINK;
                n_state = i_sts.up_free ? S_F_RDUP2 : S_F_WR;
            end
            S_F_RDUP2: begin
                o_cmd   = CMD_F_RDUP2;
                n_state = S_F_UPLCP;
            end
            S_F_UPLCP: begin
                o_cmd   = CMD_CAPLNK;
                n_state = S_F_UPUNL;
            end
            S_F_UPUNL: begin
                o_cmd   = CMD_UNLINK;
                n_state = S_F_MERGE;
            end
            S_F_MERGE: begin
                o_cmd   = CMD_F_MERGE;
                n_state = S_F_WR;
            end
            S_F_WR: begin
                o_cmd   = CMD_F_WR;
                n_state = S_PUSH1;
            end
            S_FIN_OK: begin
                o_cmd   = CMD_FIN_OK;
                n_state = S_IDLE;
            end
            S_FIN_BAD: begin
                o_cmd   = CMD_FIN_BAD;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT0;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/ffba_dp.sv]
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath: tag and link memories, free-list head, working registers and
// result register, driven by one command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_dp
    import ffba_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_func,
    input  wire logic [OFF_W-1:0]  i_req_size,
    input  wire logic [OFF_W-1:0]  i_payload_addr,
    output t_sts                   o_sts,
    output logic                   o_done,
    output logic      [OFF_W-1:0]  o_result_addr,
    output logic                   o_ok
);

    logic              r_func;
    logic [OFF_W-1:0]  r_req;
    logic [OFF_W-1:0]  r_pay;
    logic [NEED_W-1:0] r_need;
    logic [OFF_W-1:0]  r_cur;
    logic [OFF_W-1:0]  r_h;
    logic [OFF_W-1:0]  r_up;
    logic [OFF_W-1:0]  r_s;
    logic [OFF_W-1:0]  r_bs;
    logic              r_bf;
    logic [OFF_W-1:0]  r_us;
    logic              r_uf;
    logic [OFF_W-1:0]  r_new;
    logic [LINK_W-1:0] r_ln;
    logic [LINK_W-1:0] r_lp;
    logic [IDX_W-1:0]  r_head;
    logic              r_hv;
    logic [OFF_W-1:0]  r_rad;
    logic              r_done;
    logic              r_ok;
    logic [OFF_W-1:0]  r_oaddr;

    logic [IDX_W-1:0]  raddr;
    logic [TAG_W-1:0]  q_up;
    logic [TAG_W-1:0]  q_lo;
    logic [LINK_W-1:0] q_nx;
    logic [LINK_W-1:0] q_pv;

    logic              up_we;
    logic [IDX_W-1:0]  up_wa;
    logic [TAG_W-1:0]  up_wd;
    logic              lo_we;
    logic [IDX_W-1:0]  lo_wa;
    logic [TAG_W-1:0]  lo_wd;
    logic              nx_we;
    logic [IDX_W-1:0]  nx_wa;
    logic [LINK_W-1:0] nx_wd;
    logic              pv_we;
    logic [IDX_W-1:0]  pv_wa;
    logic [LINK_W-1:0] pv_wd;

    logic [OFF_W-1:0]  q_size;
    logic [NEED_W-1:0] need_min;
    logic [NEED_W-1:0] need_sum;
    logic [NEED_W-1:0] need_c;
    logic [OFF_W-1:0]  cur_idx_off;
    logic [OFF_W-1:0]  news_c;
    logic [OFF_W-1:0]  upc;
    logic [OFF_W-1:0]  top_c;
    logic [OFF_W-1:0]  walk_nxt;
    logic [OFF_W-1:0]  up_rd;
    logic [OFF_W-1:0]  lo_c;
    logic [OFF_W-1:0]  nx_off;

    assign q_size   = q_up[TAG_W-1:1];
    assign need_min = (r_req < OFF_W'(MIN_PAYLOAD)) ? NEED_W'(MIN_PAYLOAD) : {1'b0, r_req};
    assign need_sum = need_min + NEED_W'(ALIGN_BYTES - 1);
    assign need_c   = {need_sum[NEED_W-1:GRAN_W], GRAN_W'(0)};
    assign cur_idx_off = {r_head, GRAN_W'(0)};
    assign news_c   = r_s - r_need[OFF_W-1:0] - HDR_OFF;
    assign upc      = r_cur + r_s - r_need[OFF_W-1:0];
    assign top_c    = r_cur + HDR_OFF + r_s;
    assign walk_nxt = r_cur + HDR_OFF + q_size;
    assign up_rd    = r_cur + HDR_OFF + r_s;
    assign lo_c     = r_cur - r_bs - HDR_OFF;
    assign nx_off   = {q_nx[IDX_W-1:0], GRAN_W'(0)};

    always_comb begin
        o_sts.is_free    = r_func;
        o_sts.need_zero  = (r_req == '0);
        o_sts.head_valid = r_hv;
        o_sts.fit        = ({1'b0, q_size} >= r_need);
        o_sts.next_ok    = q_nx[IDX_W];
        o_sts.split_ok   = ({2'b00, r_s} >= ({1'b0, r_need}
                            + (NEED_W+1)'(MIN_PAYLOAD + HEADER_BYTES)));
        o_sts.size_zero  = (q_size == '0);
        o_sts.at_h       = (r_cur == r_h);
        o_sts.q_free     = q_up[0];
        o_sts.pay_small  = (r_pay < HDR_OFF);
        o_sts.low_free   = r_bf;
        o_sts.up_free    = r_uf;
    end

    always_comb begin
        raddr = r_cur[OFF_W-1:GRAN_W];
        up_we = 1'b0;
        up_wa = '0;
        up_wd = '0;
        lo_we = 1'b0;
        lo_wa = '0;
        lo_wd = '0;
        nx_we = 1'b0;
        nx_wa = '0;
        nx_wd = '0;
        pv_we = 1'b0;
        pv_wa = '0;
        pv_wd = '0;
        unique case (i_cmd)
            CMD_INIT0: begin
                up_we = 1'b1;
                up_wd = {INIT_SIZE, 1'b1};
                lo_we = 1'b1;
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            CMD_INIT1: begin
                up_we = 1'b1;
                up_wa = SENT_IDX;
                lo_we = 1'b1;
                lo_wa = SENT_IDX;
                lo_wd = {INIT_SIZE, 1'b1};
            end
            CMD_A_FIRST: begin
                raddr = r_head;
            end
            CMD_A_STEP: begin
                if (!o_sts.fit) begin
                    raddr = q_nx[IDX_W-1:0];
                end
            end
            CMD_UNLINK: begin
                if (r_ln[IDX_W]) begin
                    pv_we = 1'b1;
                    pv_wa = r_ln[IDX_W-1:0];
                    pv_wd = r_lp;
                end
                if (r_lp[IDX_W]) begin
                    nx_we = 1'b1;
                    nx_wa = r_lp[IDX_W-1:0];
                    nx_wd = r_ln;
                end
            end
            CMD_A_SPL1: begin
                up_we = 1'b1;
                up_wa = r_cur[OFF_W-1:GRAN_W];
                up_wd = {news_c, 1'b1};
                lo_we = 1'b1;
                lo_wa = upc[OFF_W-1:GRAN_W];
                lo_wd = {news_c, 1'b1};
            end
            CMD_A_SPL2: begin
                up_we = 1'b1;
                up_wa = r_up[OFF_W-1:GRAN_W];
                up_wd = {r_need[OFF_W-1:0], 1'b0};
                lo_we = 1'b1;
                lo_wa = top_c[OFF_W-1:GRAN_W];
                lo_wd = {r_need[OFF_W-1:0], 1'b0};
            end
            CMD_A_NOSP: begin
                up_we = 1'b1;
                up_wa = r_cur[OFF_W-1:GRAN_W];
                up_wd = {r_s, 1'b0};
                lo_we = 1'b1;
                lo_wa = top_c[OFF_W-1:GRAN_W];
                lo_wd = {r_s, 1'b0};
            end
            CMD_PUSH1: begin
                nx_we = 1'b1;
                nx_wa = r_cur[OFF_W-1:GRAN_W];
                nx_wd = {r_hv, r_head};
                pv_we = 1'b1;
                pv_wa = r_cur[OFF_W-1:GRAN_W];
            end
            CMD_PUSH2: begin
                if (r_hv) begin
                    pv_we = 1'b1;
                    pv_wa = r_head;
                    pv_wd = {1'b1, r_cur[OFF_W-1:GRAN_W]};
                end
            end
            CMD_F_SETUP: begin
                raddr = '0;
            end
            CMD_F_STEP: begin
                if (!o_sts.at_h) begin
                    raddr = walk_nxt[OFF_W-1:GRAN_W];
                end
            end
            CMD_F_RDUP: begin
                raddr = up_rd[OFF_W-1:GRAN_W];
            end
            CMD_F_RDLO: begin
                raddr = lo_c[OFF_W-1:GRAN_W];
            end
            CMD_F_RDUP2: begin
                raddr = r_up[OFF_W-1:GRAN_W];
            end
            CMD_F_WR: begin
                up_we = 1'b1;
                up_wa = r_cur[OFF_W-1:GRAN_W];
                up_wd = {r_new, 1'b1};
                lo_we = 1'b1;
                lo_wa = r_up[OFF_W-1:GRAN_W];
                lo_wd = {r_new, 1'b1};
            end
            default: begin
                raddr = r_cur[OFF_W-1:GRAN_W];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_hv   <= 1'b1;
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd == CMD_FIN_OK) || (i_cmd == CMD_FIN_BAD);
            case (i_cmd)
                CMD_LOAD: begin
                    r_func <= i_func;
                    r_req  <= i_req_size;
                    r_pay  <= i_payload_addr;
                    r_rad  <= '0;
                end
                CMD_A_SETUP: begin
                    r_need <= need_c;
                end
                CMD_A_FIRST: begin
                    r_cur <= cur_idx_off;
                end
                CMD_A_STEP: begin
                    r_s  <= q_size;
                    r_ln <= q_nx;
                    r_lp <= q_pv;
                    if (!o_sts.fit) begin
                        r_cur <= nx_off;
                    end
                end
                CMD_UNLINK: begin
                    if (!r_lp[IDX_W]) begin
                        r_head <= r_ln[IDX_W-1:0];
                        r_hv   <= r_ln[IDX_W];
                    end
                end
                CMD_A_SPL1: begin
                    r_up <= upc;
                end
                CMD_A_SPL2: begin
                    r_rad <= r_up + HDR_OFF;
                end
                CMD_A_NOSP: begin
                    r_rad <= r_cur + HDR_OFF;
                end
                CMD_PUSH2: begin
                    r_head <= r_cur[OFF_W-1:GRAN_W];
                    r_hv   <= 1'b1;
                end
                CMD_F_SETUP: begin
                    r_h   <= r_pay - HDR_OFF;
                    r_cur <= '0;
                end
                CMD_F_STEP: begin
                    r_s  <= q_size;
                    r_bs <= q_lo[TAG_W-1:1];
                    r_bf <= q_lo[0];
                    if (!o_sts.at_h) begin
                        r_cur <= walk_nxt;
                    end
                end
                CMD_F_RDUP: begin
                    r_up  <= up_rd;
                    r_new <= r_s;
                end
                CMD_F_UPCAP: begin
                    r_us <= q_size;
                    r_uf <= q_up[0];
                end
                CMD_F_RDLO: begin
                    r_cur <= lo_c;
                    r_new <= r_bs + r_new + HDR_OFF;
                end
                CMD_CAPLNK: begin
                    r_ln <= q_nx;
                    r_lp <= q_pv;
                end
                CMD_F_MERGE: begin
                    r_new <= r_new + r_us + HDR_OFF;
                    r_up  <= r_up + HDR_OFF + r_us;
                end
                CMD_FIN_OK: begin
                    r_ok    <= 1'b1;
                    r_oaddr <= r_rad;
                end
                CMD_FIN_BAD: begin
                    r_ok    <= 1'b0;
                    r_oaddr <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_result_addr = r_oaddr;

    ffba_ram #(.WIDTH(TAG_W), .DEPTH(DEPTH)) u_tag_hi (
        .i_clk   (i_clk),
        .i_we    (up_we),
        .i_waddr (up_wa),
        .i_wdata (up_wd),
        .i_raddr (raddr),
        .o_rdata (q_up)
    );

    ffba_ram #(.WIDTH(TAG_W), .DEPTH(DEPTH)) u_tag_lo (
        .i_clk   (i_clk),
        .i_we    (lo_we),
        .i_waddr (lo_wa),
        .i_wdata (lo_wd),
        .i_raddr (raddr),
        .o_rdata (q_lo)
    );

    ffba_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_link_nx (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_wa),
        .i_wdata (nx_wd),
        .i_raddr (raddr),
        .o_rdata (q_nx)
    );

    ffba_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_link_pv (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_wa),
        .i_wdata (pv_wd),
        .i_raddr (raddr),
        .o_rdata (q_pv)
    );

endmodule

`default_nettype wire
